/* sv/tte_pkg.sv */
// Package for the time tag record encoder.
// Constants, FSM state type and the controller/datapath command and status structs.
// No dependencies.
package tte_pkg;

  localparam int unsigned MacroBits    = 12;
  localparam int unsigned MaxOvfPerRec = 65536;
  localparam int unsigned MacroW       = 64;
  localparam int unsigned MicroW       = 12;
  localparam int unsigned RouteW       = 4;
  localparam int unsigned CountW       = 17;
  localparam int unsigned DistW        = 32;
  localparam int unsigned OvsW         = DistW - MacroBits;
  localparam int unsigned TotalW       = 52;

  localparam logic [MicroW-1:0] AdcFull = {MicroW{1'b1}};

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic rem_gt1;
  } sts_t;

endpackage

/* sv/tte_if.sv */
// Request channel interfaces: photon events in, encoded records out.
// Depends on tte_pkg.
interface tte_in_if;
  logic                        valid;
  logic                        ready;
  logic [tte_pkg::MacroW-1:0]  tag_time;
  logic [tte_pkg::MicroW-1:0]  micro_time;
  logic [tte_pkg::RouteW-1:0]  routing_channel;

  modport source (output valid, tag_time, micro_time, routing_channel, input ready);
  modport sink   (input valid, tag_time, micro_time, routing_channel, output ready);
endinterface

interface tte_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_overflow_record;
  logic [tte_pkg::CountW-1:0]    overflow_count;
  logic [tte_pkg::MacroBits-1:0] macro_low;
  logic [tte_pkg::MicroW-1:0]    adc_value;
  logic [tte_pkg::RouteW-1:0]    route;
  logic                          mtov_flag;
  logic                          invalid_flag;
  logic                          last_of_run;

  modport source (output valid, is_overflow_record, overflow_count, macro_low, adc_value,
                  route, mtov_flag, invalid_flag, last_of_run, input ready);
  modport sink   (input valid, is_overflow_record, overflow_count, macro_low, adc_value,
                  route, mtov_flag, invalid_flag, last_of_run, output ready);
endinterface

/* sv/tte_datapath.sv */
// Datapath: overflow total, per-request working registers and the output record register.
// Depends on tte_pkg.
module tte_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tte_pkg::cmd_t                cmd_i,
  output tte_pkg::sts_t                sts_o,
  input  logic [tte_pkg::MacroW-1:0]   tag_time_i,
  input  logic [tte_pkg::MicroW-1:0]   micro_time_i,
  input  logic [tte_pkg::RouteW-1:0]   routing_channel_i,
  output logic                         is_overflow_record_o,
  output logic [tte_pkg::CountW-1:0]   overflow_count_o,
  output logic [tte_pkg::MacroBits-1:0] macro_low_o,
  output logic [tte_pkg::MicroW-1:0]   adc_value_o,
  output logic [tte_pkg::RouteW-1:0]   route_o,
  output logic                         mtov_flag_o,
  output logic                         invalid_flag_o,
  output logic                         last_of_run_o
);
  import tte_pkg::*;

  localparam logic [OvsW-1:0] MaxOvs = OvsW'(MaxOvfPerRec);

  logic [TotalW-1:0]    total_q, total_d;
  logic [OvsW-1:0]      rem_q, rem_d;
  logic [MacroBits-1:0] low_q;
  logic [MicroW-1:0]    adc_q;
  logic [RouteW-1:0]    route_q;

  logic [DistW-1:0]     span;
  logic [OvsW-1:0]      ovs;
  logic [OvsW-1:0]      chunk;

  logic                 ovr_q;
  logic [CountW-1:0]    cnt_q;
  logic [MacroBits-1:0] mlow_q;
  logic [MicroW-1:0]    oadc_q;
  logic [RouteW-1:0]    oroute_q;
  logic                 mtov_q;
  logic                 inval_q;
  logic                 last_q;

  // distance to the last overflow boundary, modulo 2^32
  assign span  = tag_time_i[DistW-1:0] - {total_q[OvsW-1:0], {MacroBits{1'b0}}};
  assign ovs   = span[DistW-1:MacroBits];
  assign chunk = (rem_q > MaxOvs) ? MaxOvs : rem_q;

  assign sts_o.rem_gt1 = (rem_q > OvsW'(1));

  always_comb begin
    total_d = total_q;
    rem_d   = rem_q;
    if (cmd_i.load) begin
      total_d = total_q + TotalW'(ovs);
      rem_d   = ovs;
    end else if (cmd_i.emit && sts_o.rem_gt1) begin
      rem_d   = rem_q - chunk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (cmd_i.load) begin
      low_q   <= span[MacroBits-1:0];
      adc_q   <= AdcFull - micro_time_i;
      route_q <= routing_channel_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (sts_o.rem_gt1) begin
        ovr_q    <= 1'b1;
        cnt_q    <= CountW'(chunk);
        mlow_q   <= '0;
        oadc_q   <= '0;
        oroute_q <= '0;
        mtov_q   <= 1'b1;
        inval_q  <= 1'b1;
        last_q   <= 1'b0;
      end else begin
        ovr_q    <= 1'b0;
        cnt_q    <= '0;
        mlow_q   <= low_q;
        oadc_q   <= adc_q;
        oroute_q <= route_q;
        mtov_q   <= (rem_q == OvsW'(1));
        inval_q  <= 1'b0;
        last_q   <= 1'b1;
      end
    end
  end

  assign is_overflow_record_o = ovr_q;
  assign overflow_count_o     = cnt_q;
  assign macro_low_o          = mlow_q;
  assign adc_value_o          = oadc_q;
  assign route_o              = oroute_q;
  assign mtov_flag_o          = mtov_q;
  assign invalid_flag_o       = inval_q;
  assign last_of_run_o        = last_q;

endmodule

/* sv/tte_ctrl.sv */
// Controller FSM: takes a request, then steps out overflow records and the photon record.
// Depends on tte_pkg.
module tte_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  tte_pkg::sts_t sts_i,
  output tte_pkg::cmd_t cmd_o
);
  import tte_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_RUN;
      end
      S_RUN: begin
        if (slot_free && !sts_i.rem_gt1) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_RUN: begin
        cmd_o.emit = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/time_tag_record_encoder.sv */
// Top level of the time tag record encoder: controller plus datapath.
// Depends on tte_pkg, tte_if, tte_ctrl and tte_datapath.
//
//   port    dir  kind        content
//   in_i    in   tte_in_if   photon event: macro time, micro time, routing channel
//   out_o   out  tte_out_if  overflow records, then one photon record per request
//
// A request is taken in S_IDLE, then the emit loop in S_RUN steps out N overflow records,
// N from 0 to 16, and then the photon record.
// The next request is taken once the photon record is in the output register.
// Reset clears the overflow total, the FSM and the output valid.
// A stalled output holds its record and stops the emit loop.
module time_tag_record_encoder (
  input logic         clk_i,
  input logic         rst_ni,
  tte_in_if.sink      in_i,
  tte_out_if.source   out_o
);
  import tte_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tte_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .tag_time_i           (in_i.tag_time),
    .micro_time_i         (in_i.micro_time),
    .routing_channel_i    (in_i.routing_channel),
    .is_overflow_record_o (out_o.is_overflow_record),
    .overflow_count_o     (out_o.overflow_count),
    .macro_low_o          (out_o.macro_low),
    .adc_value_o          (out_o.adc_value),
    .route_o              (out_o.route),
    .mtov_flag_o          (out_o.mtov_flag),
    .invalid_flag_o       (out_o.invalid_flag),
    .last_of_run_o        (out_o.last_of_run)
  );

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("request taken while previous one in flight");

  a_ovf_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.is_overflow_record |->
      out_o.overflow_count >= CountW'(2) && out_o.overflow_count <= CountW'(MaxOvfPerRec))
    else $error("overflow record count out of range");

  a_photon_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.is_overflow_record |->
      out_o.last_of_run && !out_o.invalid_flag && out_o.overflow_count == '0)
    else $error("malformed photon record");

  a_ovf_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.is_overflow_record |-> !out_o.last_of_run && !in_i.ready)
    else $error("overflow record ends a run");

endmodule
